// ===== rtl/gha_pkg.sv =====
`timescale 1ns / 1ps

package gha_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int VER_W     = 32;
  localparam int REQ_W     = 32;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;

  // One version entry: live mark above the version.
  localparam int ENTRY_W   = VER_W + 1;

  localparam int IN_DATA_W  = 2 * REQ_W;
  localparam int OUT_RAW_W  = SLOT_W + VER_W + STATUS_W + 1 + CNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_CHECK   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DEAD = 2'd1,
    ST_FULL = 2'd2,
    ST_RSVD = 2'd3
  } status_e;

endpackage

// ===== rtl/gha_ram.sv =====
`timescale 1ns / 1ps

module gha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds its value until the next read.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/generational_handle_allocator_top.sv =====
// A create that reuses a freed slot reads the free stack, then the version memory (S_POP, then
// S_VER) before its result is registered; every other request needs at most the version read.
// One word at a time: the next word is taken only after the result is registered; a reused
// create makes two dependent reads, of the single-port free stack and then the version memory.
// Reset: rst_ni is asynchronous, active low; it clears counters and control, no memory sweep.
`timescale 1ns / 1ps

module generational_handle_allocator_top
  import gha_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [31:0] req_slot, [63:32] req_version
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] op
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [9:0] out_slot, [41:10] out_version, [43:42] status, [44] is_alive,
  // [55:45] live_total
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_VER  = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  op_e                op_q;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [VER_W-1:0]   ver_q;
  logic [CNT_W-1:0]   free_top_q, free_top_d;
  logic [CNT_W-1:0]   fresh_q, fresh_d;
  logic [CNT_W-1:0]   live_q, live_d;

  logic               out_valid_q, out_valid_d;
  logic [SLOT_W-1:0]  out_slot_q, r_slot;
  logic [VER_W-1:0]   out_ver_q, r_ver;
  status_e            out_status_q, r_status;
  logic               out_alive_q, r_alive;
  logic [CNT_W-1:0]   out_live_q;

  logic               vr_en, vr_we;
  logic [SLOT_W-1:0]  vr_addr;
  logic [ENTRY_W-1:0] vr_wdata, vr_rdata;
  logic               st_en, st_we;
  logic [SLOT_W-1:0]  st_addr, st_wdata, st_rdata;

  logic               in_acc, out_free, finishing, in_range, hit, match;
  logic [REQ_W-1:0]   req_slot;
  logic [VER_W-1:0]   req_version;
  op_e                req_op;
  logic [VER_W-1:0]   ent_ver;
  logic               ent_live;

  assign req_slot    = s_axis_tdata[REQ_W-1:0];
  assign req_version = s_axis_tdata[2*REQ_W-1:REQ_W];
  assign req_op      = op_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign finishing     = ((state_q == S_VER) || (state_q == S_RESP)) && out_free;

  // Slots at or above the fresh mark were never handed out, so they read as dead.
  assign in_range = (req_slot < REQ_W'(MAX_SLOTS)) &&
                    ({1'b0, req_slot[SLOT_W-1:0]} < fresh_q);

  assign hit      = (state_q == S_VER);
  assign ent_live = vr_rdata[VER_W];
  assign ent_ver  = vr_rdata[VER_W-1:0];
  assign match    = hit && ent_live && (ent_ver == ver_q);

  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    free_top_d = free_top_q;
    fresh_d    = fresh_q;
    live_d     = live_q;
    vr_en      = 1'b0;
    vr_we      = 1'b0;
    vr_addr    = slot_q;
    vr_wdata   = '0;
    st_en      = 1'b0;
    st_we      = 1'b0;
    st_addr    = free_top_q[SLOT_W-1:0];
    st_wdata   = slot_q;
    r_slot     = '0;
    r_ver      = '0;
    r_status   = ST_OK;
    r_alive    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          slot_d  = req_slot[SLOT_W-1:0];
          state_d = S_RESP;
          case (req_op)
            OP_CREATE: begin
              if (free_top_q != '0) begin
                st_en   = 1'b1;
                st_addr = SLOT_W'(free_top_q - CNT_W'(1));
                state_d = S_POP;
              end
            end
            OP_DESTROY, OP_CHECK: begin
              if (in_range) begin
                vr_en   = 1'b1;
                vr_addr = req_slot[SLOT_W-1:0];
                state_d = S_VER;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end

      S_POP: begin
        vr_en   = 1'b1;
        vr_addr = st_rdata;
        slot_d  = st_rdata;
        state_d = S_VER;
      end

      S_VER, S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
          case (op_q)
            OP_CREATE: begin
              if (hit) begin
                r_slot     = slot_q;
                r_ver      = ent_ver + VER_W'(1);
                free_top_d = free_top_q - CNT_W'(1);
                live_d     = live_q + CNT_W'(1);
                vr_en      = 1'b1;
                vr_we      = 1'b1;
                vr_addr    = slot_q;
                vr_wdata   = {1'b1, r_ver};
              end else if (fresh_q < CNT_W'(MAX_SLOTS)) begin
                r_slot   = fresh_q[SLOT_W-1:0];
                r_ver    = VER_W'(1);
                fresh_d  = fresh_q + CNT_W'(1);
                live_d   = live_q + CNT_W'(1);
                vr_en    = 1'b1;
                vr_we    = 1'b1;
                vr_addr  = fresh_q[SLOT_W-1:0];
                vr_wdata = {1'b1, r_ver};
              end else begin
                r_status = ST_FULL;
              end
            end
            OP_DESTROY: begin
              if (match) begin
                r_alive  = 1'b1;
                vr_en    = 1'b1;
                vr_we    = 1'b1;
                vr_addr  = slot_q;
                vr_wdata = {1'b0, ent_ver};
                if (free_top_q < CNT_W'(MAX_SLOTS)) begin
                  st_en      = 1'b1;
                  st_we      = 1'b1;
                  free_top_d = free_top_q + CNT_W'(1);
                end
                if (live_q != '0) begin
                  live_d = live_q - CNT_W'(1);
                end
              end else begin
                r_status = ST_DEAD;
              end
            end
            OP_CHECK: begin
              if (match) begin
                r_alive = 1'b1;
              end else begin
                r_status = ST_DEAD;
              end
            end
            default: r_status = ST_OK;
          endcase
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finishing) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_top_q  <= '0;
      fresh_q     <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_top_q  <= free_top_d;
      fresh_q     <= fresh_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    if (in_acc) begin
      op_q  <= req_op;
      ver_q <= req_version;
    end
    if (finishing) begin
      out_slot_q   <= r_slot;
      out_ver_q    <= r_ver;
      out_status_q <= r_status;
      out_alive_q  <= r_alive;
      out_live_q   <= live_d;
    end
  end

  gha_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLOTS)
  ) u_ver_ram (
    .clk_i   (clk_i),
    .en_i    (vr_en),
    .we_i    (vr_we),
    .addr_i  (vr_addr),
    .wdata_i (vr_wdata),
    .rdata_o (vr_rdata)
  );

  gha_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .en_i    (st_en),
    .we_i    (st_we),
    .addr_i  (st_addr),
    .wdata_i (st_wdata),
    .rdata_o (st_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_live_q, out_alive_q, out_status_q,
                                      out_ver_q, out_slot_q});

endmodule

// ===== rtl/gha_checker.sv =====
`timescale 1ns / 1ps

module gha_checker
  import gha_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [OP_W-1:0]       s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int VER_LO  = SLOT_W;
  localparam int ST_LO   = SLOT_W + VER_W;
  localparam int AL_BIT  = ST_LO + STATUS_W;
  localparam int LIVE_LO = AL_BIT + 1;

  logic [STATUS_W-1:0] out_status;
  logic                out_alive;
  logic [CNT_W-1:0]    out_live;
  logic [SLOT_W-1:0]   out_slot;
  logic [VER_W-1:0]    out_ver;

  assign out_slot   = m_axis_tdata[SLOT_W-1:0];
  assign out_ver    = m_axis_tdata[ST_LO-1:VER_LO];
  assign out_status = m_axis_tdata[AL_BIT-1:ST_LO];
  assign out_alive  = m_axis_tdata[AL_BIT];
  assign out_live   = m_axis_tdata[LIVE_LO+CNT_W-1:LIVE_LO];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  a_full_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_status == ST_FULL) |->
      (out_slot == '0) && (out_ver == '0) && !out_alive && (out_live == CNT_W'(MAX_SLOTS)))
    else $error("pool full result carries a handle or a short live count");

  a_alive_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_alive |->
      (out_status == ST_OK) && (out_slot == '0) && (out_ver == '0))
    else $error("alive result with bad status or a handle");

  a_status_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_status != ST_RSVD) && (out_live <= CNT_W'(MAX_SLOTS)))
    else $error("reserved status or live count out of range");

endmodule

bind generational_handle_allocator_top gha_checker u_gha_checker (.*);

// ===== tb/tb_generational_handle_allocator_top.sv =====
`timescale 1ns / 1ps

import gha_pkg::*;

typedef struct {
  logic [SLOT_W-1:0] slot;
  logic [VER_W-1:0]  ver;
  status_e           st;
  logic              alive;
  logic [CNT_W-1:0]  total;
} reply_t;

// Mirror of the handle pool: slot versions, live marks, the LIFO of freed slots and the
// counters, plus the replies that the block still owes.
class handle_table;
  logic [VER_W-1:0] version_of [MAX_SLOTS];
  bit               in_use     [MAX_SLOTS];
  int unsigned      free_slots [$];
  int unsigned      next_fresh;
  int unsigned      live_cnt;
  int unsigned      errors;
  int unsigned      full_replies;
  reply_t           pending_replies [$];

  function new();
    next_fresh   = 0;
    live_cnt     = 0;
    errors       = 0;
    full_replies = 0;
    foreach (in_use[i]) in_use[i] = 1'b0;
  endfunction

  function bit holds(logic [REQ_W-1:0] slot, logic [VER_W-1:0] ver);
    if (slot >= MAX_SLOTS) return 1'b0;
    return in_use[slot] && version_of[slot] == ver;
  endfunction

  function void apply_request(op_e op, logic [REQ_W-1:0] slot, logic [VER_W-1:0] ver);
    reply_t      r;
    int unsigned s;
    r.slot  = '0;
    r.ver   = '0;
    r.st    = ST_OK;
    r.alive = 1'b0;
    case (op)
      OP_CREATE: begin
        s = MAX_SLOTS;
        if (free_slots.size() > 0) begin
          s = free_slots[$];
          free_slots.delete(free_slots.size() - 1);
          r.ver = version_of[s] + 1;
        end else if (next_fresh < MAX_SLOTS) begin
          s = next_fresh;
          next_fresh++;
          r.ver = 1;
        end
        if (s < MAX_SLOTS) begin
          version_of[s] = r.ver;
          in_use[s] = 1'b1;
          live_cnt++;
          r.slot = s[SLOT_W-1:0];
        end else begin
          r.st = ST_FULL;
          full_replies++;
        end
      end
      OP_DESTROY: begin
        if (holds(slot, ver)) begin
          r.alive = 1'b1;
          in_use[slot] = 1'b0;
          free_slots.insert(free_slots.size(), slot);
          live_cnt--;
        end else begin
          r.st = ST_DEAD;
        end
      end
      OP_CHECK: begin
        if (holds(slot, ver)) r.alive = 1'b1;
        else r.st = ST_DEAD;
      end
      default: ;
    endcase
    r.total = live_cnt[CNT_W-1:0];
    pending_replies.insert(pending_replies.size(), r);
  endfunction

  function void compare_field(string name, logic [VER_W-1:0] want, logic [VER_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_reply(logic [OUT_DATA_W-1:0] word);
    reply_t want;
    if (pending_replies.size() == 0) begin
      $display("%0t: unexpected reply word, expected none, actual %0h", $time, word);
      errors++;
      return;
    end
    want = pending_replies.pop_front();
    compare_field("out_slot", want.slot, word[9:0]);
    compare_field("out_version", want.ver, word[41:10]);
    compare_field("status", want.st, word[43:42]);
    compare_field("is_alive", want.alive, word[44]);
    compare_field("live_total", want.total, word[55:45]);
  endfunction
endclass

module tb_generational_handle_allocator_top;

  localparam int RAND_ITEMS  = 1130;
  localparam int HOLD_CYCLES = 250;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [31:0] req_slot, [63:32] req_version
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // [1:0] op
  logic [OP_W-1:0]       s_axis_tuser = OP_NONE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [9:0] out_slot, [41:10] out_version, [43:42] status, [44] is_alive,
  // [55:45] live_total
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  handle_table sb;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;

  generational_handle_allocator_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Result side: random back-pressure (none while calm), and one long hold-off that stalls the block.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
  end

  task automatic send_word(op_e op, logic [REQ_W-1:0] slot, logic [VER_W-1:0] ver);
    while (!calm && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ver, slot};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_request(op, slot, ver);
  endtask

  // Only slots that were handed out at least once are addressed in range, so the
  // block never reads a version entry that was never written.
  task automatic pick_handle(output logic [REQ_W-1:0] slot, output logic [VER_W-1:0] ver);
    int unsigned roll;
    int unsigned s;
    int unsigned tries;
    roll = $urandom_range(99);
    if (roll < 8 || sb.next_fresh == 0) begin
      slot = $urandom_range(32'hFFFF_FFFF, MAX_SLOTS);
      ver  = $urandom;
    end else begin
      s = $urandom_range(sb.next_fresh - 1);
      tries = 0;
      while (!sb.in_use[s] && tries < 8) begin
        s = $urandom_range(sb.next_fresh - 1);
        tries++;
      end
      slot = s;
      ver  = sb.version_of[s];
      if (roll < 14) ver = $urandom;
      else if (roll < 22) ver = ver ^ (32'h1 << $urandom_range(31));
    end
  endtask

  task automatic run_directed();
    send_word(OP_NONE, '0, '0);
    send_word(OP_CHECK, MAX_SLOTS, '0);
    send_word(OP_DESTROY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_CREATE, '0, '0);
    send_word(OP_CREATE, $urandom, $urandom);
    send_word(OP_CHECK, 0, 1);
    send_word(OP_CHECK, 0, 2);
    send_word(OP_CHECK, 0, 32'hFFFF_FFFF);
    send_word(OP_DESTROY, 1, 1);
    send_word(OP_DESTROY, 1, 1);
    send_word(OP_CHECK, 1, 1);
    send_word(OP_DESTROY, 2, 1);
    // Freed slots come back last in, first out, each with its version bumped.
    send_word(OP_CREATE, $urandom, $urandom);
    send_word(OP_CREATE, $urandom, $urandom);
    send_word(OP_CREATE, $urandom, $urandom);
    // Out-of-range slots whose low bits alias live slots must not match.
    send_word(OP_CHECK, MAX_SLOTS + 1, 2);
    send_word(OP_DESTROY, 32'h8000_0002, 2);
    send_word(OP_NONE, $urandom, $urandom);
  endtask

  // Mostly creates until the pool is used up, then a mix that keeps hitting the full pool.
  task automatic run_random();
    int unsigned      n;
    int unsigned      roll;
    logic [REQ_W-1:0] slot;
    logic [VER_W-1:0] ver;
    op_e              op;
    n = 0;
    while ((n < RAND_ITEMS || sb.full_replies < 8) && n < 4000) begin
      calm = (n >= 300 && n < 500);
      if (n == 40) hold_off = 1'b1;
      roll = $urandom_range(99);
      slot = $urandom;
      ver  = $urandom;
      if (sb.next_fresh < MAX_SLOTS) begin
        op = roll < 92 ? OP_CREATE : roll < 96 ? OP_DESTROY : roll < 99 ? OP_CHECK : OP_NONE;
      end else begin
        op = roll < 50 ? OP_CREATE : roll < 70 ? OP_DESTROY : roll < 90 ? OP_CHECK : OP_NONE;
      end
      if (op == OP_DESTROY || op == OP_CHECK) pick_handle(slot, ver);
      send_word(op, slot, ver);
      n++;
    end
    calm = 1'b0;
  endtask

  initial begin
    sb = new();
    wait (rst_ni);
    @(posedge clk_i);
    run_directed();
    run_random();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== generational_handle_allocator_top.f =====
rtl/gha_pkg.sv
rtl/gha_ram.sv
rtl/generational_handle_allocator_top.sv
rtl/gha_checker.sv
tb/tb_generational_handle_allocator_top.sv
